>>> src/trb_pkg.sv
// Shared types and constants for the TRB ring producer.
// No dependencies; imported by every module of the block.
package trb_pkg;

  // Item action codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_RESET = 1'b1;

  // TRB field constants
  localparam int unsigned TRB_TYPE_SHIFT = 10;
  localparam logic [31:0] TRB_TYPE_LINK  = 32'd6;
  localparam logic [31:0] LINK_TOGGLE    = 32'h0000_0002;
  localparam logic [31:0] CYCLE_BIT      = 32'h0000_0001;
  localparam logic [31:0] LINK_WORD3     = (TRB_TYPE_LINK << TRB_TYPE_SHIFT) | LINK_TOGGLE;

  // Classified command passed from front to back
  typedef struct packed {
    logic        action;  // ACT_PUSH or ACT_RESET
    logic        wrap;    // push fills the slot before the link
    logic        cyc;     // cycle bit to apply
    logic [63:0] addr;    // slot address of the data TRB
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;      // control word, cycle bit already merged
  } trb_cmd_t;

  // One memory write on the output side
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic        is_link;
    logic        last;
  } trb_wr_t;

endpackage

>>> src/trb_ring_producer.sv
// TRB ring producer: the front classifies each accepted item into the queue at the accept edge,
// and the back end then loads the output register from the queue head.
// Throughput is one item per cycle while out_ready stays high; a push that fills the last
// data slot holds the back end for the extra link write.
// Reset (rst, synchronous): index 0, cycle 1, ring_base 0, queue and output empty.
// Depends on trb_pkg, trb_front, trb_cmd_fifo and trb_back.
module trb_ring_producer import trb_pkg::*; #(
  parameter int RING_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: ring base address
  input  logic        cfg_write_en,
  input  logic [63:0] cfg_write_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] param_low,
  input  logic [31:0] param_high,
  input  logic [31:0] status_word,
  input  logic [31:0] control_word,
  // memory writes
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] write_address,
  output logic [31:0] word0,
  output logic [31:0] word1,
  output logic [31:0] word2,
  output logic [31:0] word3,
  output logic        is_link,
  output logic        last
);

  logic [63:0] ring_base;
  logic        in_accept;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  trb_cmd_t    front_cmd;
  trb_cmd_t    q_head;
  trb_wr_t     wr;

  // Hold the ring base; the user must write it only while the block is idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= '0;
    end else if (cfg_write_en) begin
      ring_base <= cfg_write_data;
    end
  end

  // Accept whenever the queue has room; the back end drains it independently
  assign in_ready  = ~q_full;
  assign in_accept = in_valid && in_ready;

  trb_front #(
    .RING_ENTRIES(RING_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .action      (action),
    .param_low   (param_low),
    .param_high  (param_high),
    .status_word (status_word),
    .control_word(control_word),
    .ring_base   (ring_base),
    .cmd         (front_cmd)
  );

  trb_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // Emit one write per cycle while out_ready stays high; a wrapping push yields data then link
  trb_back #(
    .RING_ENTRIES(RING_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ring_base(ring_base),
    .cmd_valid(q_not_empty),
    .cmd      (q_head),
    .cmd_pop  (q_pop),
    .wr_valid (out_valid),
    .wr_ready (out_ready),
    .wr       (wr)
  );

  assign write_address = wr.addr;
  assign word0         = wr.w0;
  assign word1         = wr.w1;
  assign word2         = wr.w2;
  assign word3         = wr.w3;
  assign is_link       = wr.is_link;
  assign last          = wr.last;

`ifndef SYNTH
  // A link write always closes the item's writes
  a_link_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!is_link || last))
    else $error("link write not marked last");

  // A data write that is not last is followed at once by the link write
  a_link_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && is_link))
    else $error("link write did not follow wrapping data write");

  // Reset empties the output register and opens the input
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("reset did not clear output and queue");
`endif

endmodule

>>> src/trb_front.sv
// Front end: accepts items, tracks enqueue index and producer cycle.
// Depends on trb_pkg for the command type and action codes.
module trb_front import trb_pkg::*; #(
  parameter int RING_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        action,
  input  logic [31:0] param_low,
  input  logic [31:0] param_high,
  input  logic [31:0] status_word,
  input  logic [31:0] control_word,
  input  logic [63:0] ring_base,
  output trb_cmd_t    cmd
);

  localparam int IDX_W = (RING_ENTRIES - 1 > 1) ? $clog2(RING_ENTRIES - 1) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_ENTRIES - 2);

  logic [IDX_W-1:0] enqueue_index, enqueue_index_next;
  logic             producer_cycle, producer_cycle_next;
  logic             wrap;

  assign wrap = (enqueue_index == IDX_LAST);

  always_comb begin
    enqueue_index_next  = enqueue_index;
    producer_cycle_next = producer_cycle;
    if (accept) begin
      if (action == ACT_RESET) begin
        enqueue_index_next  = '0;
        producer_cycle_next = 1'b1;
      end else if (wrap) begin
        enqueue_index_next  = '0;
        producer_cycle_next = ~producer_cycle;
      end else begin
        enqueue_index_next  = enqueue_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enqueue_index  <= '0;
      producer_cycle <= 1'b1;
    end else begin
      enqueue_index  <= enqueue_index_next;
      producer_cycle <= producer_cycle_next;
    end
  end

  // Classify the item; address uses the slot index before advance
  always_comb begin
    cmd.action = action;
    cmd.wrap   = (action == ACT_PUSH) && wrap;
    cmd.cyc    = (action == ACT_RESET) ? 1'b1 : producer_cycle;
    cmd.addr   = ring_base + {{(60 - IDX_W){1'b0}}, enqueue_index, 4'b0000};
    cmd.w0     = param_low;
    cmd.w1     = param_high;
    cmd.w2     = status_word;
    cmd.w3     = control_word | {31'd0, producer_cycle};
  end

endmodule

>>> src/trb_cmd_fifo.sv
// Two-entry command queue between front and back.
// Depends on trb_pkg for the command type.
module trb_cmd_fifo import trb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  trb_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output trb_cmd_t head
);

  trb_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/trb_back.sv
// Back end: turns queued commands into data and link TRB writes.
// Depends on trb_pkg for command and write types.
module trb_back import trb_pkg::*; #(
  parameter int RING_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] ring_base,
  input  logic        cmd_valid,
  input  trb_cmd_t    cmd,
  output logic        cmd_pop,
  output logic        wr_valid,
  input  logic        wr_ready,
  output trb_wr_t     wr
);

  localparam logic [63:0] LINK_OFS = 64'((RING_ENTRIES - 1) * 16);
  localparam logic PH_DATA = 1'b0;
  localparam logic PH_LINK = 1'b1;

  logic    phase, phase_next;
  logic    load;
  logic    emit_link;
  trb_wr_t wr_next;

  assign load      = cmd_valid && (!wr_valid || wr_ready);
  assign emit_link = (cmd.action == ACT_RESET) || (phase == PH_LINK);
  assign cmd_pop   = load && (!cmd.wrap || phase == PH_LINK);

  always_comb begin
    phase_next = phase;
    if (load && cmd.wrap) begin
      phase_next = ~phase;
    end
  end

  always_comb begin
    if (emit_link) begin
      wr_next.addr    = ring_base + LINK_OFS;
      wr_next.w0      = ring_base[31:0];
      wr_next.w1      = ring_base[63:32];
      wr_next.w2      = '0;
      wr_next.w3      = LINK_WORD3 | (cmd.cyc ? CYCLE_BIT : 32'd0);
      wr_next.is_link = 1'b1;
      wr_next.last    = 1'b1;
    end else begin
      wr_next.addr    = cmd.addr;
      wr_next.w0      = cmd.w0;
      wr_next.w1      = cmd.w1;
      wr_next.w2      = cmd.w2;
      wr_next.w3      = cmd.w3;
      wr_next.is_link = 1'b0;
      wr_next.last    = ~cmd.wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_DATA;
      wr_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        wr_valid <= 1'b1;
      end else if (wr_ready) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr <= wr_next;
    end
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for trb_ring_producer: drives TRB push and ring reset items,
// predicts every memory write (data TRB and link TRB) and checks each one in order.
// Depends on trb_pkg and trb_ring_producer only.
module tb;
  import trb_pkg::*;

  localparam int          RING_ENTRIES = 256;
  localparam logic [63:0] TRB_BYTES    = 64'd16;

  // One input item as the sender sees it
  typedef struct packed {
    logic        act;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] st;
    logic [31:0] ctrl;
  } trb_item_t;

  // Receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;

  // Block inputs start at known values before the first edge
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_write_en   = 1'b0;
  logic [63:0] cfg_write_data = '0;
  logic        in_valid       = 1'b0;
  logic        action         = ACT_PUSH;
  logic [31:0] param_low      = '0;
  logic [31:0] param_high     = '0;
  logic [31:0] status_word    = '0;
  logic [31:0] control_word   = '0;
  logic        out_ready      = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [63:0] write_address;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic        is_link;
  logic        last;

  trb_ring_producer #(.RING_ENTRIES(RING_ENTRIES)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .param_low     (param_low),
    .param_high    (param_high),
    .status_word   (status_word),
    .control_word  (control_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .word0         (word0),
    .word1         (word1),
    .word2         (word2),
    .word3         (word3),
    .is_link       (is_link),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor: own copy of the producer state and the ring base register.
  // ---------------------------------------------------------------------------
  logic [63:0] ring_base_m = '0;
  int unsigned ring_idx    = 0;
  logic        ring_cyc    = 1'b1;
  trb_wr_t     pending_writes[$];   // writes still owed by the block, oldest first
  int          errors = 0;

  // Link TRB in the last slot: points back at the base, toggle-cycle set.
  function automatic trb_wr_t link_write(input logic cyc);
    trb_wr_t w;
    w.addr    = ring_base_m + 64'(RING_ENTRIES - 1) * TRB_BYTES;
    w.w0      = ring_base_m[31:0];
    w.w1      = ring_base_m[63:32];
    w.w2      = '0;
    w.w3      = LINK_WORD3 | {31'b0, cyc};
    w.is_link = 1'b1;
    w.last    = 1'b1;
    return w;
  endfunction

  // Advance the ring by one accepted item and queue the writes it causes.
  function automatic void advance_ring(input trb_item_t it);
    trb_wr_t w;
    logic    cyc;
    if (it.act == ACT_RESET) begin
      // restart at slot 0 with cycle 1; data fields are don't-care
      ring_idx = 0;
      ring_cyc = 1'b1;
      pending_writes.push_back(link_write(1'b1));
    end else begin
      cyc       = ring_cyc;
      w.addr    = ring_base_m + 64'(ring_idx) * TRB_BYTES;
      w.w0      = it.p0;
      w.w1      = it.p1;
      w.w2      = it.st;
      w.w3      = it.ctrl | {31'b0, cyc};   // OR, so a preset cycle bit survives
      w.is_link = 1'b0;
      ring_idx++;
      if (ring_idx >= RING_ENTRIES - 1) begin
        // last data slot: refresh the link with the old cycle, then flip and wrap
        w.last = 1'b0;
        pending_writes.push_back(w);
        pending_writes.push_back(link_write(cyc));
        ring_cyc = ~cyc;
        ring_idx = 0;
      end else begin
        w.last = 1'b1;
        pending_writes.push_back(w);
      end
    end
  endfunction

  // Count every failure, print only the first ten.
  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Write checker: pop the oldest expectation on every accepted write.
  // ---------------------------------------------------------------------------
  trb_wr_t got_wr;
  trb_wr_t exp_wr;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_wr = '{addr: write_address, w0: word0, w1: word1, w2: word2, w3: word3,
                 is_link: is_link, last: last};
      if (pending_writes.size() == 0) begin
        note_error($sformatf("write with nothing expected: addr %h w3 %h link %b",
                             got_wr.addr, got_wr.w3, got_wr.is_link));
      end else begin
        exp_wr = pending_writes.pop_front();
        if (got_wr !== exp_wr)
          note_error($sformatf({"write mismatch\n  exp addr %h w %h %h %h %h link %b last %b",
                                "\n  got addr %h w %h %h %h %h link %b last %b"},
                               exp_wr.addr, exp_wr.w0, exp_wr.w1, exp_wr.w2, exp_wr.w3,
                               exp_wr.is_link, exp_wr.last,
                               got_wr.addr, got_wr.w0, got_wr.w1, got_wr.w2, got_wr.w3,
                               got_wr.is_link, got_wr.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns at random; a requested hold-off
  // drops ready for a fixed count of cycles, counted here.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  int       rx_phase     = 0;
  int       hold_len     = 0;
  int       hold_asked   = 0;
  int       hold_done    = 0;

  always @(posedge clk) begin
    if (hold_asked != hold_done) begin
      rx_hold_left = hold_len;
      hold_done    = hold_asked;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        RX_QUARTER: out_ready <= (rx_phase % 4 == 0);
        default:    out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  bit pace_on    = 1'b1;
  int burst_left = 0;

  // Present one item, hold it until accepted, then predict its writes.
  // Valid is left high; the caller drops it in a gap or at the end of a stream.
  task automatic send_item(input trb_item_t it);
    in_valid     <= 1'b1;
    action       <= it.act;
    param_low    <= it.p0;
    param_high   <= it.p1;
    status_word  <= it.st;
    control_word <= it.ctrl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_ring(it);
  endtask

  // Burst pacing: count down the burst, then idle for a random gap.
  task automatic pace();
    int gap;
    if (pace_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  // Wait for every owed write, bounded, then let the pipeline settle.
  task automatic wait_idle();
    int guard = 0;
    while (pending_writes.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_ring_base(input logic [63:0] base);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= base;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    ring_base_m = base;
  endtask

  function automatic trb_item_t make_item(input logic act, input logic [31:0] p0,
                                          input logic [31:0] p1, input logic [31:0] st,
                                          input logic [31:0] ctrl);
    return '{act: act, p0: p0, p1: p1, st: st, ctrl: ctrl};
  endfunction

  // Mostly random words, with all-zero and all-one words mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Pushes with random content; one in reset_odds is a ring reset (0: never).
  function automatic trb_item_t random_item(input int reset_odds);
    logic act;
    act = (reset_odds > 0 && $urandom_range(1, reset_odds) == 1) ? ACT_RESET : ACT_PUSH;
    return make_item(act, pick_word(), pick_word(), pick_word(), pick_word());
  endfunction

  task automatic run_items(input int count, input int reset_odds);
    repeat (count) begin
      send_item(random_item(reset_odds));
      pace();
    end
    in_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, preset cycle bits, reset items and wrapping addresses.
  task automatic test_directed();
    send_item(make_item(ACT_PUSH, '0, '0, '0, '0));
    send_item(make_item(ACT_PUSH, '1, '1, '1, '1));
    send_item(make_item(ACT_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554));
    send_item(make_item(ACT_PUSH, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(make_item(ACT_PUSH, 32'h1, 32'h8000_0000, 32'h1, CYCLE_BIT));
    send_item(make_item(ACT_RESET, '1, '1, '1, '1));
    send_item(make_item(ACT_PUSH, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h8000_0000));
    in_valid <= 1'b0;
    wait_idle();
    // top of the address space: data and link addresses wrap past 2^64
    write_ring_base('1);
    send_item(make_item(ACT_PUSH, '0, '0, '0, '0));
    send_item(make_item(ACT_PUSH, '1, '1, '1, '1));
    send_item(make_item(ACT_RESET, '0, '0, '0, '0));
    send_item(make_item(ACT_PUSH, $urandom(), $urandom(), $urandom(), $urandom()));
    in_valid <= 1'b0;
    wait_idle();
    write_ring_base(64'hFFFF_FFFF_FFFF_F000);
    send_item(make_item(ACT_PUSH, '1, '0, '1, '0));
    send_item(make_item(ACT_RESET, $urandom(), $urandom(), $urandom(), $urandom()));
    send_item(make_item(ACT_PUSH, '0, '1, '0, CYCLE_BIT));
    in_valid <= 1'b0;
    wait_idle();
  endtask

  // Long runs of pushes with no ring reset: two wraps, both cycle values,
  // and the cycle bit ORed onto control words in the cycle-0 pass.
  task automatic test_ring_wraps();
    write_ring_base({$urandom(), $urandom() & 32'hFFFF_F000});
    run_items(350, 0);
    // pause until the block has drained, then carry on from the same slot
    wait_idle();
    run_items(350, 0);
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps offering items back to back,
  // so the block fills up and drops in_ready.
  task automatic test_backpressure();
    hold_len = 400;
    hold_asked++;
    pace_on = 1'b0;
    run_items(80, 20);
    pace_on = 1'b1;
    wait_idle();
  endtask

  // Several ring bases, including the extremes, with occasional ring resets.
  task automatic test_ring_base_sweep();
    logic [63:0] bases[5];
    bases[0] = {$urandom(), $urandom()};
    bases[1] = 64'h8000_0000_0000_0000;
    bases[2] = '1;
    bases[3] = {$urandom(), $urandom() & 32'hFFFF_F000};
    bases[4] = '0;
    foreach (bases[i]) begin
      write_ring_base(bases[i]);
      pace_on = (i % 2 == 0);   // alternate paced and unbroken streams
      run_items(120, 40);
      wait_idle();
    end
    pace_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_ring_wraps();
    test_backpressure();
    test_ring_base_sweep();
    wait_idle();
    if (pending_writes.size() != 0)
      note_error($sformatf("%0d expected writes never arrived", pending_writes.size()));
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("tb failed");
    $finish;
  end

endmodule
